// ===== design/adts_pkg.sv =====
// Package with the shared types, constants and the header unpack function of the ADTS delimiter.
package adts_pkg;

    // Bytes from the first sync byte to the end of the fixed-size header area.
    localparam int HEADER_BYTES = 7;
    // Width of the running byte position within one buffer.
    localparam int OFFSET_BITS = 24;
    // Width of the header byte counter.
    localparam int HDR_CNT_W = 4;

    // Byte values used for sync detection.
    localparam logic [7:0] SYNC_BYTE   = 8'hff;
    localparam logic [3:0] SYNC_NIBBLE = 4'hf;

    // Result status codes.
    localparam logic [1:0] STATUS_COMPLETE = 2'd0;
    localparam logic [1:0] STATUS_PARTIAL  = 2'd1;
    localparam logic [1:0] STATUS_NO_SYNC  = 2'd2;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    // One input request.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } adts_in_t;

    // One result request.
    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] frame_offset;
        logic [15:0] payload_size;
        logic        mpeg_id;
        logic [1:0]  layer_bits;
        logic        crc_absent;
        logic [1:0]  profile_bits;
        logic [3:0]  rate_index;
        logic        private_flag;
        logic [2:0]  channel_setup;
        logic        original_flag;
        logic        home_flag;
    } adts_out_t;

    // Build a result from the captured header bytes (byte 1 in the top eight bits).
    function automatic adts_out_t make_result(
        input logic [1:0]             status,
        input logic [OFFSET_BITS-1:0] offset,
        input logic [15:0]            size,
        input logic [23:0]            capture
    );
        adts_out_t r;
        r.status        = status;
        r.frame_offset  = 24'(offset);
        r.payload_size  = size;
        r.mpeg_id       = capture[19];
        r.layer_bits    = capture[18:17];
        r.crc_absent    = capture[16];
        r.profile_bits  = capture[15:14];
        r.rate_index    = capture[13:10];
        r.private_flag  = capture[9];
        r.channel_setup = {capture[8], capture[7:6]};
        r.original_flag = capture[5];
        r.home_flag     = capture[4];
        return r;
    endfunction

endpackage

// ===== design/adts_frame_delimiter.sv =====
// Top level of the ADTS frame delimiter: input register, per-byte parser and result register.
//
// The block takes one stream byte per cycle and returns at most one result per byte: a
// finished frame (offset of its first sync byte, payload size, fixed header fields) when the
// next sync turns up in the payload, and at the last byte of a buffer either the open frame
// or a no-sync report. A new byte can be accepted every cycle; the byte behind a result passes the
// input register, and the parser then loads the result into the result register for the m_ side.
// The rate is set by the single parser state update done for each byte between the input register
// and the result register, and it holds as long as results are taken. All state returns to its
// reset values after the last byte of each buffer, so buffers are parsed independently.
module adts_frame_delimiter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  adts_pkg::adts_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output adts_pkg::adts_out_t m_data
);

    localparam int OW = adts_pkg::OFFSET_BITS;
    localparam int CW = adts_pkg::HDR_CNT_W;

    // Input stage.
    logic                in_valid_reg;
    adts_pkg::adts_in_t  in_reg;

    // Parser state.
    adts_pkg::phase_t    phase_reg, phase_step, phase_next;
    logic [7:0]          prev_byte_reg, prev_byte_next;
    logic                prev_in_payload_reg, prev_in_payload_step, prev_in_payload_next;
    logic [OW-1:0]       byte_pos_reg, byte_pos_next;
    logic [OW-1:0]       start_offset_reg, start_offset_step, start_offset_next;
    logic [CW-1:0]       header_count_reg, header_count_step, header_count_next;
    logic [23:0]         capture_reg, capture_step, capture_next;
    logic [15:0]         payload_count_reg, payload_count_step, payload_count_next;

    // Result stage.
    logic                m_valid_reg;
    adts_pkg::adts_out_t m_data_reg, result;

    logic                advance;
    logic                sync;
    logic                frame_close;
    logic                frame_begin;
    logic                last;
    logic [CW-1:0]       header_count_inc;
    logic                header_done;
    logic                has_result;
    logic [15:0]         partial_size;

    // The parser moves when a byte is held and the result slot is free or being emptied.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sync and frame boundary detection on the held byte.
    assign last             = in_reg.end_of_buffer;
    assign sync             = (prev_byte_reg == adts_pkg::SYNC_BYTE) &&
                              (in_reg.data_byte[7:4] == adts_pkg::SYNC_NIBBLE);
    assign frame_close      = (phase_reg == adts_pkg::PH_PAYLOAD) && prev_in_payload_reg && sync;
    assign frame_begin      = ((phase_reg == adts_pkg::PH_HUNT) && sync) || frame_close;
    assign header_count_inc = header_count_reg + CW'(1);
    assign header_done      = ({1'b0, header_count_inc} + (CW+1)'(1)) >=
                              (CW+1)'(adts_pkg::HEADER_BYTES);
    assign has_result       = frame_close || last;

    // Next phase: the step for this byte, then the buffer-end clear.
    always_comb begin
        phase_step = phase_reg;
        unique case (phase_reg)
            adts_pkg::PH_HUNT: begin
                if (sync) begin
                    phase_step = adts_pkg::PH_HEADER;
                end
            end
            adts_pkg::PH_HEADER: begin
                if (header_done) begin
                    phase_step = adts_pkg::PH_PAYLOAD;
                end
            end
            adts_pkg::PH_PAYLOAD: begin
                if (frame_close) begin
                    phase_step = adts_pkg::PH_HEADER;
                end
            end
            default: begin
                phase_step = adts_pkg::PH_HUNT;
            end
        endcase
        phase_next = last ? adts_pkg::PH_HUNT : phase_step;
    end

    // Counters, header capture and the result for this byte.
    always_comb begin
        start_offset_step    = start_offset_reg;
        capture_step         = capture_reg;
        header_count_step    = header_count_reg;
        payload_count_step   = payload_count_reg;
        prev_in_payload_step = prev_in_payload_reg;

        if (frame_begin) begin
            start_offset_step    = byte_pos_reg - OW'(1);
            capture_step         = {in_reg.data_byte, 16'd0};
            header_count_step    = CW'(1);
            payload_count_step   = 16'd0;
            prev_in_payload_step = 1'b0;
        end else if (phase_reg == adts_pkg::PH_HEADER) begin
            header_count_step = header_count_inc;
            if (header_count_inc == CW'(2)) begin
                capture_step[15:8] = in_reg.data_byte;
            end else if (header_count_inc == CW'(3)) begin
                capture_step[7:0] = in_reg.data_byte;
            end
        end else if (phase_reg == adts_pkg::PH_PAYLOAD) begin
            if (prev_in_payload_reg && (payload_count_reg != 16'hffff)) begin
                payload_count_step = payload_count_reg + 16'd1;
            end
            prev_in_payload_step = 1'b1;
        end

        // An open frame at buffer end also counts the last payload byte.
        partial_size = payload_count_step;
        if (prev_in_payload_step && (payload_count_step != 16'hffff)) begin
            partial_size = payload_count_step + 16'd1;
        end

        if (frame_close) begin
            result = adts_pkg::make_result(adts_pkg::STATUS_COMPLETE, start_offset_reg,
                                           payload_count_reg, capture_reg);
        end else if (phase_step == adts_pkg::PH_HUNT) begin
            result = adts_pkg::make_result(adts_pkg::STATUS_NO_SYNC, OW'(0), 16'd0, 24'd0);
        end else begin
            result = adts_pkg::make_result(adts_pkg::STATUS_PARTIAL, start_offset_step,
                                           partial_size, capture_step);
        end

        // The last byte of a buffer returns everything to the reset values.
        if (last) begin
            prev_byte_next       = 8'd0;
            byte_pos_next        = '0;
            start_offset_next    = '0;
            capture_next         = 24'd0;
            header_count_next    = '0;
            payload_count_next   = 16'd0;
            prev_in_payload_next = 1'b0;
        end else begin
            prev_byte_next       = in_reg.data_byte;
            byte_pos_next        = byte_pos_reg + OW'(1);
            start_offset_next    = start_offset_step;
            capture_next         = capture_step;
            header_count_next    = header_count_step;
            payload_count_next   = payload_count_step;
            prev_in_payload_next = prev_in_payload_step;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= adts_pkg::PH_HUNT;
            prev_byte_reg       <= 8'd0;
            prev_in_payload_reg <= 1'b0;
            byte_pos_reg        <= '0;
            start_offset_reg    <= '0;
            header_count_reg    <= '0;
            capture_reg         <= 24'd0;
            payload_count_reg   <= 16'd0;
        end else if (advance) begin
            phase_reg           <= phase_next;
            prev_byte_reg       <= prev_byte_next;
            prev_in_payload_reg <= prev_in_payload_next;
            byte_pos_reg        <= byte_pos_next;
            start_offset_reg    <= start_offset_next;
            header_count_reg    <= header_count_next;
            capture_reg         <= capture_next;
            payload_count_reg   <= payload_count_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && has_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && has_result) begin
            m_data_reg <= result;
        end
    end

    // The header counter stays inside the header area while the header is skipped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == adts_pkg::PH_HEADER) |->
            ((header_count_reg != '0) &&
             (({1'b0, header_count_reg} + (CW+1)'(1)) < (CW+1)'(adts_pkg::HEADER_BYTES))))
        else $error("header counter out of range during header");

    // No payload is counted while hunting for a sync.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == adts_pkg::PH_HUNT) |->
            ((payload_count_reg == 16'd0) && !prev_in_payload_reg))
        else $error("payload state not clear while hunting");

    // The last byte of a buffer always clears the parser.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last) |=>
            ((phase_reg == adts_pkg::PH_HUNT) && (byte_pos_reg == '0) && !prev_in_payload_reg))
        else $error("parser not cleared after buffer end");

    // A waiting result is never overwritten by the parser.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !advance)
        else $error("parser advanced over a stalled result");

    // A produced result is presented in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && has_result) |=> m_valid_reg)
        else $error("result lost");

endmodule

// ===== tb/sv/adts_frame_delimiter_test.sv =====
// Self-checking testbench for the ADTS frame delimiter with a built-in frame tracker.
module adts_frame_delimiter_test;

    // Run limits and stimulus sizes.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 460;
    localparam int SETTLE_CYCLES  = 10;
    localparam int MAX_REPORTS    = 10;
    localparam logic [15:0] SIZE_MAX = 16'hffff;

    // Idle percentages of the sender and the receiver in each random phase.
    localparam int SEND_IDLE  [4] = '{0, 54, 0, 16};
    localparam int RECV_STALL [4] = '{0, 0, 54, 16};

    // Results of the directed rows that can be written down directly.
    localparam adts_pkg::adts_out_t NO_SYNC_REPORT = '{adts_pkg::STATUS_NO_SYNC, 24'd0, 16'd0,
        1'b0, 2'd0, 1'b0, 2'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0};
    localparam adts_pkg::adts_out_t ONES_PARTIAL = '{adts_pkg::STATUS_PARTIAL, 24'd1, 16'd2,
        1'b1, 2'd3, 1'b1, 2'd3, 4'd15, 1'b1, 3'd7, 1'b1, 1'b1};
    localparam adts_pkg::adts_out_t CLOSED_ON_LAST = '{adts_pkg::STATUS_COMPLETE, 24'd0, 16'd1,
        1'b0, 2'd0, 1'b0, 2'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0};

    typedef struct packed {
        adts_pkg::adts_in_t  req;
        logic                typed;
        adts_pkg::adts_out_t want;
    } dir_row_t;

    // Directed rows: buffer-end cases, all-ones and all-zeros headers, sync rules.
    localparam dir_row_t DIR_ROWS [25] = '{
        '{'{8'h00, 1'b1}, 1'b1, NO_SYNC_REPORT},   // one-byte buffer, no sync
        '{'{8'hff, 1'b1}, 1'b1, NO_SYNC_REPORT},   // 0xFF ends the buffer
        '{'{8'hf0, 1'b0}, 1'b0, '0},               // must not pair with that 0xFF
        '{'{8'hff, 1'b0}, 1'b0, '0},
        '{'{8'hff, 1'b0}, 1'b0, '0},               // sync at offset 1
        '{'{8'hff, 1'b0}, 1'b0, '0},
        '{'{8'hff, 1'b0}, 1'b0, '0},
        '{'{8'hff, 1'b0}, 1'b0, '0},               // header bytes are not searched
        '{'{8'hff, 1'b0}, 1'b0, '0},
        '{'{8'hff, 1'b0}, 1'b0, '0},
        '{'{8'hff, 1'b0}, 1'b0, '0},               // first payload byte
        '{'{8'h00, 1'b1}, 1'b1, ONES_PARTIAL},     // buffer ends in the payload
        '{'{8'hff, 1'b0}, 1'b0, '0},
        '{'{8'hf0, 1'b0}, 1'b0, '0},               // sync at offset 0
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h11, 1'b0}, 1'b0, '0},
        '{'{8'hff, 1'b0}, 1'b0, '0},
        '{'{8'hf5, 1'b1}, 1'b1, CLOSED_ON_LAST},   // closing sync on the last byte
        '{'{8'hff, 1'b0}, 1'b0, '0},
        '{'{8'hfa, 1'b0}, 1'b0, '0},
        '{'{8'h5c, 1'b1}, 1'b0, '0}                // buffer ends inside the header
    };

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    adts_pkg::adts_in_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    adts_pkg::adts_out_t m_data;

    // Frame tracker state, one copy of what the block keeps per buffer.
    adts_pkg::phase_t                 trk_phase;
    logic [7:0]                       prev_byte;
    logic                             prev_in_payload;
    logic [adts_pkg::OFFSET_BITS-1:0] byte_pos;
    logic [adts_pkg::OFFSET_BITS-1:0] frame_start;
    logic [adts_pkg::HDR_CNT_W-1:0]   hdr_count;
    logic [23:0]                      hdr_bytes;
    logic [15:0]                      payload_bytes;

    adts_pkg::adts_out_t frame_q [$];
    logic [7:0]          stream_q [$];
    int                  fail_count = 0;
    int                  idle_cycles = 0;
    int                  send_idle = 0;
    int                  recv_stall = 0;
    int                  hold_left = 0;
    bit                  hold_req = 1'b0;

    adts_frame_delimiter DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void clear_tracker();
        trk_phase       = adts_pkg::PH_HUNT;
        prev_byte       = '0;
        prev_in_payload = 1'b0;
        byte_pos        = '0;
        frame_start     = '0;
        hdr_count       = '0;
        hdr_bytes       = '0;
        payload_bytes   = '0;
    endfunction

    // A sync starts a frame at the offset of its 0xFF byte.
    function automatic void open_frame(input logic [7:0] cur);
        frame_start     = byte_pos - 1'b1;
        hdr_bytes       = {cur, 16'h0000};
        hdr_count       = {{(adts_pkg::HDR_CNT_W-1){1'b0}}, 1'b1};
        payload_bytes   = '0;
        prev_in_payload = 1'b0;
        trk_phase       = adts_pkg::PH_HEADER;
    endfunction

    // Unpack the fixed header fields from the three captured bytes.
    function automatic adts_pkg::adts_out_t frame_report(input logic [1:0] st,
                                                         input logic [15:0] size);
        adts_pkg::adts_out_t r;
        logic [7:0]          b1;
        logic [7:0]          b2;
        logic [7:0]          b3;
        b1 = hdr_bytes[23:16];
        b2 = hdr_bytes[15:8];
        b3 = hdr_bytes[7:0];
        r.status        = st;
        r.frame_offset  = 24'(frame_start);
        r.payload_size  = size;
        r.mpeg_id       = b1[3];
        r.layer_bits    = b1[2:1];
        r.crc_absent    = b1[0];
        r.profile_bits  = b2[7:6];
        r.rate_index    = b2[5:2];
        r.private_flag  = b2[1];
        r.channel_setup = {b2[0], b3[7:6]};
        r.original_flag = b3[5];
        r.home_flag     = b3[4];
        return r;
    endfunction

    // Advance the tracker by one byte; returns 1 when the byte yields a result.
    function automatic bit track_byte(input adts_pkg::adts_in_t req,
                                      output adts_pkg::adts_out_t res);
        logic [7:0]  cur;
        logic        sync;
        logic [15:0] partial;
        bit          found;
        cur   = req.data_byte;
        sync  = (prev_byte == adts_pkg::SYNC_BYTE) && (cur[7:4] == adts_pkg::SYNC_NIBBLE);
        found = 1'b0;
        res   = '0;
        case (trk_phase)
            adts_pkg::PH_HUNT: begin
                if (sync) open_frame(cur);
            end
            adts_pkg::PH_HEADER: begin
                hdr_count = hdr_count + 1'b1;
                if (hdr_count == 2) hdr_bytes[15:8] = cur;
                else if (hdr_count == 3) hdr_bytes[7:0] = cur;
                if (int'(hdr_count) + 1 >= adts_pkg::HEADER_BYTES)
                    trk_phase = adts_pkg::PH_PAYLOAD;
            end
            default: begin
                // Only a sync whose 0xFF byte is payload closes the frame.
                if (prev_in_payload && sync) begin
                    res   = frame_report(adts_pkg::STATUS_COMPLETE, payload_bytes);
                    found = 1'b1;
                    open_frame(cur);
                end else begin
                    if (prev_in_payload && payload_bytes != SIZE_MAX)
                        payload_bytes = payload_bytes + 1'b1;
                    prev_in_payload = 1'b1;
                end
            end
        endcase
        prev_byte = cur;
        byte_pos  = byte_pos + 1'b1;

        // The last byte of a buffer reports the open frame or the lack of a sync.
        if (req.end_of_buffer) begin
            if (!found) begin
                if (trk_phase == adts_pkg::PH_HUNT) begin
                    res        = '0;
                    res.status = adts_pkg::STATUS_NO_SYNC;
                end else begin
                    partial = payload_bytes;
                    if (prev_in_payload && partial != SIZE_MAX) partial = partial + 1'b1;
                    res = frame_report(adts_pkg::STATUS_PARTIAL, partial);
                end
                found = 1'b1;
            end
            clear_tracker();
        end
        return found;
    endfunction

    function automatic string describe(input adts_pkg::adts_out_t r);
        return $sformatf({"st=%0d off=%h size=%0d id=%b layer=%0d crc=%b prof=%0d ",
            "rate=%0d priv=%b ch=%0d orig=%b home=%b"}, r.status, r.frame_offset,
            r.payload_size, r.mpeg_id, r.layer_bits, r.crc_absent, r.profile_bits,
            r.rate_index, r.private_flag, r.channel_setup, r.original_flag, r.home_flag);
    endfunction

    task automatic note_mismatch(input string what, input adts_pkg::adts_out_t want,
                                 input adts_pkg::adts_out_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s: expected %s, got %s", what, describe(want), describe(got));
    endtask

    // Offer one request with random idle cycles ahead of it and record what it yields.
    task automatic push_byte(input adts_pkg::adts_in_t req, input bit typed,
                             input adts_pkg::adts_out_t want);
        adts_pkg::adts_out_t res;
        bit                  found;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        found = track_byte(req, res);
        if (typed) frame_q.push_back(want);
        else if (found) frame_q.push_back(res);
    endtask

    // Stop offering and wait until every pending result has been taken.
    task automatic drain();
        s_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge aclk);
    endtask

    // Build one buffer: mostly whole frames with random content, some cut, some noise.
    function automatic void fill_buffer();
        int         plen;
        int         cut;
        logic [7:0] b;
        stream_q.delete();
        if ($urandom_range(99) < 80) begin
            repeat ($urandom_range(3)) stream_q.push_back(8'($urandom));
            repeat ($urandom_range(1, 4)) begin
                stream_q.push_back(adts_pkg::SYNC_BYTE);
                stream_q.push_back({adts_pkg::SYNC_NIBBLE, 4'($urandom)});
                repeat (adts_pkg::HEADER_BYTES - 2) stream_q.push_back(8'($urandom));
                plen = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(12);
                repeat (plen) begin
                    b = 8'($urandom);
                    // Keep stray syncs in the payload uncommon.
                    if (b == adts_pkg::SYNC_BYTE && $urandom_range(3) != 0) b = 8'h7f;
                    stream_q.push_back(b);
                end
            end
            if ($urandom_range(3) == 0) begin
                cut = $urandom_range(1, stream_q.size());
                while (stream_q.size() > cut) void'(stream_q.pop_back());
            end
        end else begin
            repeat ($urandom_range(1, 24))
                stream_q.push_back(($urandom_range(3) == 0) ? adts_pkg::SYNC_BYTE
                                                            : 8'($urandom));
        end
    endfunction

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Compare each result with the oldest pending expectation.
    always @(posedge aclk) begin
        adts_pkg::adts_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_q.size() == 0) begin
                note_mismatch("result with nothing pending", '0, m_data);
            end else begin
                want = frame_q.pop_front();
                if (want.status !== m_data.status || want.frame_offset !== m_data.frame_offset
                        || want.payload_size !== m_data.payload_size
                        || want.mpeg_id !== m_data.mpeg_id
                        || want.layer_bits !== m_data.layer_bits
                        || want.crc_absent !== m_data.crc_absent
                        || want.profile_bits !== m_data.profile_bits
                        || want.rate_index !== m_data.rate_index
                        || want.private_flag !== m_data.private_flag
                        || want.channel_setup !== m_data.channel_setup
                        || want.original_flag !== m_data.original_flag
                        || want.home_flag !== m_data.home_flag)
                    note_mismatch("result mismatch", want, m_data);
            end
        end
    end

    // Watchdog on cycles without any request moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int sent;
        clear_tracker();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[i]) push_byte(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].want);

        for (int p = 0; p < 4; p++) begin
            drain();
            @(negedge aclk);
            send_idle  = SEND_IDLE[p];
            recv_stall = RECV_STALL[p];
            @(posedge aclk);

            if (p == 0) begin
                // Hold the receiver off while one-byte buffers keep coming.
                drain();
                @(negedge aclk);
                hold_req = 1'b1;
                @(posedge aclk);
                repeat (40)
                    push_byte(adts_pkg::adts_in_t'{8'($urandom), 1'b1}, 1'b0, '0);
            end

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                fill_buffer();
                foreach (stream_q[k]) begin
                    push_byte(adts_pkg::adts_in_t'{stream_q[k], k == stream_q.size() - 1},
                              1'b0, '0);
                    sent++;
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && frame_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
